[design/icv_pkg.sv]
// Shared constants and types for the 3x3 image convolution core.
package icv_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // Column index, column count (holds MAX_WIDTH itself), row count (runs to height + 1).
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);

    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;

    localparam int RST_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL = 2'd0,
        CFG_COLOR  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        K_GY      = 3'd0,
        K_GX      = 3'd1,
        K_SHARPEN = 3'd2,
        K_LAPLACE = 3'd3,
        K_BOX     = 3'd4
    } t_kernel;

    // Which window rows and columns fall outside the frame.
    typedef struct packed {
        logic kill_row0;
        logic kill_row2;
        logic kill_col0;
        logic kill_col2;
    } t_mask;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] middle;
    } t_line_entry;

endpackage

[design/icv_in_if.sv]
// Input pixel channel of the convolution core.
interface icv_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] sample_0;
    logic [7:0] sample_1;
    logic [7:0] sample_2;

    modport source (output valid, command, sample_0, sample_1, sample_2, input ready);
    modport sink   (input valid, command, sample_0, sample_1, sample_2, output ready);
endinterface

[design/icv_out_if.sv]
// Result pixel channel of the convolution core.
interface icv_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_0;
    logic [7:0] result_1;
    logic [7:0] result_2;
    logic       frame_last;

    modport source (output valid, result_0, result_1, result_2, frame_last, input ready);
    modport sink   (input valid, result_0, result_1, result_2, frame_last, output ready);
endinterface

[design/icv_line_buf.sv]
// Two-line pixel store with registered read and write-to-read forwarding.
module icv_line_buf (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [icv_pkg::COL_W-1:0]  i_rd_addr,
    input  logic                       i_wr_en,
    input  logic [icv_pkg::COL_W-1:0]  i_wr_addr,
    input  icv_pkg::t_line_entry       i_wr_data,
    output icv_pkg::t_line_entry       o_rd_data
);

    icv_pkg::t_line_entry r_mem [icv_pkg::MAX_WIDTH];
    icv_pkg::t_line_entry r_rd_data;
    icv_pkg::t_line_entry r_fwd_data;
    logic                 r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A write to the entry being read in the same cycle wins over the stale array data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_data;

endmodule

[design/icv_filter.sv]
// 3x3 window registers and the per-channel kernel arithmetic with clamping.
module icv_filter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_shift,
    input  logic [icv_pkg::PIX_W-1:0]  i_up,
    input  logic [icv_pkg::PIX_W-1:0]  i_mid,
    input  logic [icv_pkg::PIX_W-1:0]  i_pix,
    input  icv_pkg::t_mask             i_mask,
    input  icv_pkg::t_kernel           i_kernel,
    input  logic                       i_color,
    output logic [7:0]                 o_result_0,
    output logic [7:0]                 o_result_1,
    output logic [7:0]                 o_result_2
);

    logic [icv_pkg::PIX_W-1:0] r_win [3][3];
    logic [2:0][7:0]           res;

    function automatic logic [7:0] conv3x3(input icv_pkg::t_kernel k,
                                           input logic [8:0][7:0] p);
        logic signed [12:0] a, b, c, d, e, f, g, h, m, s;
        a = signed'({5'd0, p[0]});
        b = signed'({5'd0, p[1]});
        c = signed'({5'd0, p[2]});
        d = signed'({5'd0, p[3]});
        e = signed'({5'd0, p[4]});
        f = signed'({5'd0, p[5]});
        g = signed'({5'd0, p[6]});
        h = signed'({5'd0, p[7]});
        m = signed'({5'd0, p[8]});
        unique case (k)
            icv_pkg::K_GY: begin
                s = (a + (b <<< 1) + c) - (g + (h <<< 1) + m);
            end
            icv_pkg::K_GX: begin
                s = (a + (d <<< 1) + g) - (c + (f <<< 1) + m);
            end
            icv_pkg::K_SHARPEN: begin
                s = ((e <<< 2) + e) - (b + d + f + h);
            end
            icv_pkg::K_LAPLACE: begin
                s = (e <<< 2) - (b + d + f + h);
            end
            default: begin
                s = a + b + c + d + e + f + g + h + m;
            end
        endcase
        if (s < 0) begin
            return 8'd0;
        end else if (s > 13'sd255) begin
            return 8'd255;
        end
        return s[7:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_up;
            r_win[1][2] <= i_mid;
            r_win[2][2] <= i_pix;
        end
    end

    // Taps outside the frame are forced to zero before the kernel sums.
    always_comb begin
        logic [8:0][7:0] taps;
        logic            keep;
        taps = '0;
        res  = '0;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    keep = !((i == 0) && i_mask.kill_row0) && !((i == 2) && i_mask.kill_row2)
                        && !((j == 0) && i_mask.kill_col0) && !((j == 2) && i_mask.kill_col2);
                    taps[i*3+j] = keep ? r_win[i][j][ch*8 +: 8] : 8'd0;
                end
            end
            res[ch] = conv3x3(i_kernel, taps);
        end
    end

    assign o_result_0 = res[0];
    assign o_result_1 = i_color ? res[1] : 8'd0;
    assign o_result_2 = i_color ? res[2] : 8'd0;

endmodule

[design/image_convolution_3x3_core.sv]
// Top level of the streaming 3x3 image convolution core.
//
//  channel  | dir | payload                                   | request moves
//  i_in     | in  | command, sample_0..sample_2               | one pixel or drain tick
//  o_out    | out | result_0..result_2, frame_last            | one filtered pixel
//  i_cfg_*  | in  | index, data (kernel, color, width, height)| one register write
//
// One item per clock sustained while the output is not stalled. An item passes
// through the line-store read stage and the kernel stage, then sits in the
// output register. Synchronous active-low reset clears the counters and valid
// flags; the line stores need no clearing. A stalled output backs up through
// the stages into i_in.ready.
module image_convolution_3x3_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [icv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [icv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    icv_in_if.sink                           i_in,
    icv_out_if.source                        o_out
);

    // Configuration.
    icv_pkg::t_kernel            r_kernel;
    logic                        r_color;
    logic [icv_pkg::WCNT_W-1:0]  r_width;
    logic [icv_pkg::ROW_W-1:0]   r_height;

    // Frame position of the next item.
    logic [icv_pkg::COL_W-1:0]   r_col;
    logic [icv_pkg::ROW_W-1:0]   r_row;
    logic [icv_pkg::COL_W-1:0]   n_col;
    logic [icv_pkg::ROW_W-1:0]   n_row;

    // Read stage.
    logic                        r_a_valid;
    logic [icv_pkg::PIX_W-1:0]   r_a_pix;
    logic [icv_pkg::COL_W-1:0]   r_a_col;
    logic                        r_a_emit;
    icv_pkg::t_mask              r_a_mask;
    logic                        r_a_last;

    // Kernel stage.
    logic                        r_b_valid;
    icv_pkg::t_mask              r_b_mask;
    logic                        r_b_last;

    // Output register.
    logic                        r_o_valid;
    logic [7:0]                  r_o_res_0;
    logic [7:0]                  r_o_res_1;
    logic [7:0]                  r_o_res_2;
    logic                        r_o_last;

    logic                        in_fire;
    logic                        a_adv;
    logic                        b_adv;
    logic                        at_col0;
    logic                        emit;
    logic                        last;
    icv_pkg::t_mask              mask;
    logic [icv_pkg::ROW_W-1:0]   row_p1;
    logic [icv_pkg::WCNT_W-1:0]  col_inc;
    logic [icv_pkg::PIX_W-1:0]   in_pix;
    logic [icv_pkg::CFG_WID_W-1:0] cfg_w;
    logic [icv_pkg::CFG_HGT_W-1:0] cfg_h;
    icv_pkg::t_line_entry        lb_rd;
    icv_pkg::t_line_entry        lb_wr;
    logic [7:0]                  f_res_0;
    logic [7:0]                  f_res_1;
    logic [7:0]                  f_res_2;

    // The read stage may not move while the kernel stage still uses the window.
    assign b_adv   = r_b_valid && (!r_o_valid || o_out.ready);
    assign a_adv   = r_a_valid && (!r_b_valid || b_adv);
    assign i_in.ready = !r_a_valid || a_adv;
    assign in_fire = i_in.valid && i_in.ready;

    assign in_pix = i_in.command ? '0 : {i_in.sample_2, i_in.sample_1, i_in.sample_0};

    // The pixel finished by this item lies one row and one column behind the counters.
    always_comb begin
        at_col0        = (r_col == '0);
        emit           = (r_row > icv_pkg::ROW_W'(1)) || ((r_row == icv_pkg::ROW_W'(1)) && !at_col0);
        mask.kill_col2 = at_col0;
        mask.kill_col0 = (r_col == icv_pkg::COL_W'(1))
                      || (at_col0 && (r_width == icv_pkg::WCNT_W'(1)));
        mask.kill_row0 = at_col0 ? (r_row == icv_pkg::ROW_W'(2)) : (r_row == icv_pkg::ROW_W'(1));
        row_p1         = at_col0 ? (r_row - icv_pkg::ROW_W'(1)) : r_row;
        mask.kill_row2 = (row_p1 >= r_height);
        last           = mask.kill_row2 && mask.kill_col2;

        col_inc = {1'b0, r_col} + icv_pkg::WCNT_W'(1);
        if (emit && last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= r_width) begin
            n_col = '0;
            n_row = r_row + icv_pkg::ROW_W'(1);
        end else begin
            n_col = col_inc[icv_pkg::COL_W-1:0];
            n_row = r_row;
        end
    end

    assign cfg_w = i_cfg_data[icv_pkg::CFG_WID_W-1:0];
    assign cfg_h = i_cfg_data[icv_pkg::CFG_HGT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= icv_pkg::K_BOX;
            r_color  <= 1'b0;
            r_width  <= icv_pkg::WCNT_W'(icv_pkg::RST_WIDTH);
            r_height <= icv_pkg::ROW_W'(icv_pkg::RST_HEIGHT);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            unique case (icv_pkg::t_cfg_reg'(i_cfg_index))
                icv_pkg::CFG_KERNEL: begin
                    if (i_cfg_data[2:0] > 3'd4) begin
                        r_kernel <= icv_pkg::K_BOX;
                    end else begin
                        r_kernel <= icv_pkg::t_kernel'(i_cfg_data[2:0]);
                    end
                end
                icv_pkg::CFG_COLOR: begin
                    r_color <= i_cfg_data[0];
                end
                icv_pkg::CFG_WIDTH: begin
                    if (cfg_w == '0) begin
                        r_width <= icv_pkg::WCNT_W'(1);
                    end else if (int'(cfg_w) > icv_pkg::MAX_WIDTH) begin
                        r_width <= icv_pkg::WCNT_W'(icv_pkg::MAX_WIDTH);
                    end else begin
                        r_width <= icv_pkg::WCNT_W'(cfg_w);
                    end
                    r_col <= '0;
                    r_row <= '0;
                end
                icv_pkg::CFG_HEIGHT: begin
                    if (cfg_h == '0) begin
                        r_height <= icv_pkg::ROW_W'(1);
                    end else if (int'(cfg_h) > icv_pkg::MAX_HEIGHT) begin
                        r_height <= icv_pkg::ROW_W'(icv_pkg::MAX_HEIGHT);
                    end else begin
                        r_height <= icv_pkg::ROW_W'(cfg_h);
                    end
                    r_col <= '0;
                    r_row <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_fire) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= r_a_emit;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_pix  <= in_pix;
            r_a_col  <= r_col;
            r_a_emit <= emit;
            r_a_mask <= mask;
            r_a_last <= last;
        end
        if (a_adv) begin
            r_b_mask <= r_a_mask;
            r_b_last <= r_a_last;
        end
        if (b_adv) begin
            r_o_res_0 <= f_res_0;
            r_o_res_1 <= f_res_1;
            r_o_res_2 <= f_res_2;
            r_o_last  <= r_b_last;
        end
    end

    // The middle line moves up and the new pixel becomes the middle line.
    assign lb_wr.upper  = lb_rd.middle;
    assign lb_wr.middle = r_a_pix;

    icv_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (r_col),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_col),
        .i_wr_data (lb_wr),
        .o_rd_data (lb_rd)
    );

    icv_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (a_adv),
        .i_up       (lb_rd.upper),
        .i_mid      (lb_rd.middle),
        .i_pix      (r_a_pix),
        .i_mask     (r_b_mask),
        .i_kernel   (r_kernel),
        .i_color    (r_color),
        .o_result_0 (f_res_0),
        .o_result_1 (f_res_1),
        .o_result_2 (f_res_2)
    );

    assign o_out.valid      = r_o_valid;
    assign o_out.result_0   = r_o_res_0;
    assign o_out.result_1   = r_o_res_1;
    assign o_out.result_2   = r_o_res_2;
    assign o_out.frame_last = r_o_last;

endmodule
